@@ src/eul_rot_pkg.sv @@
`default_nettype none

package eul_rot_pkg;

  // Field widths and fixed-point format
  localparam int COORD_WIDTH    = 16;
  localparam int TRIG_FRAC_BITS = 14;
  localparam int TRIG_WIDTH     = 16;

  // Configuration port geometry: six registers at 4-byte spacing
  localparam int NUM_REGS   = 6;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = $clog2(NUM_REGS) + 2;

  // Matrix entry: clamped to [-2^(F+1), +2^(F+1)]
  localparam int ENTRY_W = TRIG_FRAC_BITS + 3;

  // Matrix build widths
  localparam int PAIR_W = 2 * TRIG_WIDTH;
  localparam int TRIP_W = 3 * TRIG_WIDTH;
  localparam int RAW_A  = 3 * TRIG_WIDTH - 1;
  localparam int RAW_B  = 2 * TRIG_WIDTH + TRIG_FRAC_BITS;
  localparam int RAW_C  = TRIG_WIDTH + 2 * TRIG_FRAC_BITS;
  localparam int RAW_AB = (RAW_A > RAW_B) ? RAW_A : RAW_B;
  localparam int RAW_W  = ((RAW_AB > RAW_C) ? RAW_AB : RAW_C) + 1;

  // Point datapath widths
  localparam int PROD_W = ENTRY_W + COORD_WIDTH;
  localparam int SUM_W  = PROD_W + 2;

  // Register stages from trig registers to matrix entries
  localparam int MAT_LAT  = 3;
  localparam int SETTLE_W = $clog2(MAT_LAT);

  typedef logic signed [TRIG_WIDTH-1:0]  trig_word_t;
  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [ENTRY_W-1:0]     entry_t;

  typedef struct packed {
    trig_word_t sx;
    trig_word_t cx;
    trig_word_t sy;
    trig_word_t cy;
    trig_word_t sz;
    trig_word_t cz;
  } trig_t;

  typedef enum logic [CFG_ADDR_W-3:0] {
    REG_SIN_AX,
    REG_COS_AX,
    REG_SIN_AY,
    REG_COS_AY,
    REG_SIN_AZ,
    REG_COS_AZ
  } reg_idx_t;

  localparam trig_word_t TRIG_ONE = trig_word_t'(64'd1 << TRIG_FRAC_BITS);

endpackage

`default_nettype wire

@@ src/eul_rot_pt_if.sv @@
`default_nettype none

interface eul_rot_pt_if;
  import eul_rot_pkg::*;

  logic   valid;
  logic   ready;
  coord_t in_x;
  coord_t in_y;
  coord_t in_z;

  modport source (output valid, output in_x, output in_y, output in_z, input ready);
  modport sink   (input valid, input in_x, input in_y, input in_z, output ready);
endinterface

`default_nettype wire

@@ src/eul_rot_res_if.sv @@
`default_nettype none

interface eul_rot_res_if;
  import eul_rot_pkg::*;

  logic   valid;
  logic   ready;
  coord_t out_x;
  coord_t out_y;
  coord_t out_z;
  logic   clipped;

  modport source (output valid, output out_x, output out_y, output out_z, output clipped,
                  input ready);
  modport sink   (input valid, input out_x, input out_y, input out_z, input clipped,
                  output ready);
endinterface

`default_nettype wire

@@ src/euler_xyz_point_rotator_core.sv @@
`default_nettype none

// The four-stage point pipeline holds each point in pin, prod, acc and res in turn,
// taking one point per cycle while rot is ready and input is not held off. A stage stalls
// only when full and its successor stalls. A three-stage pipeline rebuilds the matrix
// from the trig registers; after reset or any register write, input is held off while it
// refills. Reset (synchronous, active high) clears all valid bits and loads zero angles.
module euler_xyz_point_rotator_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [eul_rot_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [eul_rot_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [eul_rot_pkg::CFG_DATA_W-1:0] prdata,
  output logic                               pready,
  eul_rot_pt_if.sink                         pt,
  eul_rot_res_if.source                      rot
);
  import eul_rot_pkg::*;

  localparam int F = TRIG_FRAC_BITS;

  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  localparam sum_t HALF_F = sum_t'(1) <<< (F - 1);
  localparam sum_t CMAX   = sum_t'({1'b0, {(COORD_WIDTH - 1){1'b1}}});
  localparam sum_t CMIN   = -CMAX - sum_t'(1);
  localparam logic [SETTLE_W-1:0] SETTLE_LOAD = SETTLE_W'(MAT_LAT - 1);

  trig_t               trig;
  logic                cfg_wr;
  reg_idx_t            reg_idx;
  logic [SETTLE_W-1:0] settle;
  entry_t              mat [9];

  logic   accept;
  logic   rdy1, rdy2, rdy3, rdy4;
  logic   v1, v2, v3, v4;
  coord_t pin [3];
  prod_t  prod_next [9];
  prod_t  prod [9];
  sum_t   acc_next [3];
  sum_t   acc [3];
  sum_t   sh [3];
  coord_t res_next [3];
  logic   clip_next;
  coord_t res [3];
  logic   clipped;

  // Configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      trig.sx <= '0;
      trig.cx <= TRIG_ONE;
      trig.sy <= '0;
      trig.cy <= TRIG_ONE;
      trig.sz <= '0;
      trig.cz <= TRIG_ONE;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_SIN_AX: trig.sx <= pwdata[TRIG_WIDTH-1:0];
        REG_COS_AX: trig.cx <= pwdata[TRIG_WIDTH-1:0];
        REG_SIN_AY: trig.sy <= pwdata[TRIG_WIDTH-1:0];
        REG_COS_AY: trig.cy <= pwdata[TRIG_WIDTH-1:0];
        REG_SIN_AZ: trig.sz <= pwdata[TRIG_WIDTH-1:0];
        REG_COS_AZ: trig.cz <= pwdata[TRIG_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Read back the raw register pattern
  always_comb begin
    unique case (reg_idx)
      REG_SIN_AX: prdata = CFG_DATA_W'($unsigned(trig.sx));
      REG_COS_AX: prdata = CFG_DATA_W'($unsigned(trig.cx));
      REG_SIN_AY: prdata = CFG_DATA_W'($unsigned(trig.sy));
      REG_COS_AY: prdata = CFG_DATA_W'($unsigned(trig.cy));
      REG_SIN_AZ: prdata = CFG_DATA_W'($unsigned(trig.sz));
      REG_COS_AZ: prdata = CFG_DATA_W'($unsigned(trig.cz));
      default:    prdata = '0;
    endcase
  end

  // Hold off input until the matrix pipeline reflects the registers
  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      settle <= SETTLE_LOAD;
    end else if (settle != '0) begin
      settle <= settle - SETTLE_W'(1);
    end
  end

  eul_rot_matrix u_matrix (
    .clk  (clk),
    .trig (trig),
    .mat  (mat)
  );

  // Stall chain: a stage advances when empty or when the next one advances
  assign rdy4     = !v4 || rot.ready;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign pt.ready = rdy1 && (settle == '0);
  assign accept   = pt.valid && pt.ready;

  // Stage 1: capture the point
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pin[0] <= pt.in_x;
      pin[1] <= pt.in_y;
      pin[2] <= pt.in_z;
    end
  end

  // Stage 2: nine entry-by-coordinate products
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_next[3 * r + c] = prod_t'(mat[3 * r + c]) * prod_t'(pin[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      for (int i = 0; i < 9; i++) begin
        prod[i] <= prod_next[i];
      end
    end
  end

  // Stage 3: row sums with the rounding offset folded in
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc_next[r] = sum_t'(prod[3 * r]) + sum_t'(prod[3 * r + 1])
                  + sum_t'(prod[3 * r + 2]) + HALF_F;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      for (int r = 0; r < 3; r++) begin
        acc[r] <= acc_next[r];
      end
    end
  end

  // Stage 4: drop fraction bits and saturate
  always_comb begin
    clip_next = 1'b0;
    for (int r = 0; r < 3; r++) begin
      sh[r] = acc[r] >>> F;
      if (sh[r] > CMAX) begin
        res_next[r] = CMAX[COORD_WIDTH-1:0];
        clip_next   = 1'b1;
      end else if (sh[r] < CMIN) begin
        res_next[r] = CMIN[COORD_WIDTH-1:0];
        clip_next   = 1'b1;
      end else begin
        res_next[r] = sh[r][COORD_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (rdy4) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3) begin
      for (int r = 0; r < 3; r++) begin
        res[r] <= res_next[r];
      end
      clipped <= clip_next;
    end
  end

  // Output transaction
  assign rot.valid   = v4;
  assign rot.out_x   = res[0];
  assign rot.out_y   = res[1];
  assign rot.out_z   = res[2];
  assign rot.clipped = clipped;

  // No point may enter right after a register write
  assert property (@(posedge clk) disable iff (rst) cfg_wr |=> !accept)
    else $error("point accepted while matrix pipeline refills");

  // An accepted point occupies the first stage on the next cycle
  assert property (@(posedge clk) disable iff (rst) accept |=> v1)
    else $error("accepted point lost at pipeline entry");

  // A full row-sum stage behind a stalled output holds its contents
  assert property (@(posedge clk) disable iff (rst)
    v4 && !rot.ready && v3 |=> v3 && $stable(acc[0]) && $stable(acc[1]) && $stable(acc[2]))
    else $error("row sums changed under stall");

endmodule

`default_nettype wire

@@ src/eul_rot_matrix.sv @@
`default_nettype none

module eul_rot_matrix (
  input  logic                clk,
  input  eul_rot_pkg::trig_t  trig,
  output eul_rot_pkg::entry_t mat [9]
);
  import eul_rot_pkg::*;

  localparam int F = TRIG_FRAC_BITS;

  typedef logic signed [PAIR_W-1:0] pair_t;
  typedef logic signed [TRIP_W-1:0] trip_t;
  typedef logic signed [RAW_W-1:0]  raw_t;

  localparam raw_t HALF = raw_t'(1) <<< (2 * F - 1);
  localparam raw_t LIM  = raw_t'(1) <<< (F + 1);

  // Stage A: products of two trig values
  pair_t      cycz, cysz, sxcy, cxcy, sxsy, cxsy, cxsz, cxcz, sxsz, sxcz;
  trig_word_t sy_a, sz_a, cz_a;

  // Stage B: exact entries in Q.3F
  trip_t t_sxsy_cz, t_sxsy_sz, t_cxsy_cz, t_cxsy_sz;
  raw_t  raw_next [9];
  raw_t  raw      [9];

  // Form pairwise products
  always_ff @(posedge clk) begin
    cycz <= trig.cy * trig.cz;
    cysz <= trig.cy * trig.sz;
    sxcy <= trig.sx * trig.cy;
    cxcy <= trig.cx * trig.cy;
    sxsy <= trig.sx * trig.sy;
    cxsy <= trig.cx * trig.sy;
    cxsz <= trig.cx * trig.sz;
    cxcz <= trig.cx * trig.cz;
    sxsz <= trig.sx * trig.sz;
    sxcz <= trig.sx * trig.cz;
    sy_a <= trig.sy;
    sz_a <= trig.sz;
    cz_a <= trig.cz;
  end

  // Combine into exact Q.3F entries; Q.2F pair products are scaled up by F,
  // the bare sine by 2F
  always_comb begin
    t_sxsy_cz = sxsy * cz_a;
    t_sxsy_sz = sxsy * sz_a;
    t_cxsy_cz = cxsy * cz_a;
    t_cxsy_sz = cxsy * sz_a;
    raw_next[0] = raw_t'(cycz) <<< F;
    raw_next[1] = -(raw_t'(cysz) <<< F);
    raw_next[2] = raw_t'(sy_a) <<< (2 * F);
    raw_next[3] = raw_t'(t_sxsy_cz) + (raw_t'(cxsz) <<< F);
    raw_next[4] = (raw_t'(cxcz) <<< F) - raw_t'(t_sxsy_sz);
    raw_next[5] = -(raw_t'(sxcy) <<< F);
    raw_next[6] = (raw_t'(sxsz) <<< F) - raw_t'(t_cxsy_cz);
    raw_next[7] = raw_t'(t_cxsy_sz) + (raw_t'(sxcz) <<< F);
    raw_next[8] = raw_t'(cxcy) <<< F;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 9; i++) begin
      raw[i] <= raw_next[i];
    end
  end

  // Round to F fraction bits, ties up, then clamp to +/-2
  function automatic entry_t round_clamp(raw_t v);
    raw_t r;
    r = (v + HALF) >>> (2 * F);
    if (r > LIM) begin
      r = LIM;
    end else if (r < -LIM) begin
      r = -LIM;
    end
    return r[ENTRY_W-1:0];
  endfunction

  // Stage C: registered matrix entries
  always_ff @(posedge clk) begin
    for (int i = 0; i < 9; i++) begin
      mat[i] <= round_clamp(raw[i]);
    end
  end

endmodule

`default_nettype wire

@@ test/tb_euler_xyz_point_rotator_core.sv @@
`timescale 1ns / 100ps

module tb_euler_xyz_point_rotator_core;
  import eul_rot_pkg::*;

  localparam int CLK_PERIOD       = 12;
  localparam int RESET_CYCLES     = 7;
  localparam int PIPE_LATENCY     = 3;
  localparam int LONG_HOLD_CYCLES = 150;
  localparam int MAX_REPORTS      = 10;
  localparam int TIMEOUT_CYCLES   = 400000;
  localparam int ADDR_SLOTS       = 1 << (CFG_ADDR_W - 2);

  localparam longint COORD_MAX = (longint'(1) << (COORD_WIDTH - 1)) - 1;
  localparam longint COORD_MIN = -COORD_MAX - 1;
  localparam longint ENTRY_LIM = longint'(1) << (TRIG_FRAC_BITS + 1);
  localparam real    PI        = 3.14159265358979;

  localparam trig_word_t TRIG_MIN  = 16'sh8000;
  localparam trig_word_t TRIG_MAX  = 16'sh7fff;
  localparam trig_word_t TRIG_ZERO = 16'sh0000;
  localparam trig_t TRIG_IDENTITY  = {TRIG_ZERO, TRIG_ONE, TRIG_ZERO, TRIG_ONE,
                                      TRIG_ZERO, TRIG_ONE};

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   clipped;
  } rot_result_t;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  eul_rot_pt_if  pt_bus ();
  eul_rot_res_if rot_bus ();

  // Trig values the block should hold right now
  trig_t       trig_now;
  rot_result_t rot_expect_q[$];
  int          mismatch_count;
  bit          src_gaps_on;
  bit          sink_stalls_on;
  int          holds_asked;
  int          holds_served;

  euler_xyz_point_rotator_core DUT (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .pt      (pt_bus),
    .rot     (rot_bus)
  );

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // Round to nearest, ties up, dropping s fraction bits
  function automatic longint round_drop(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clamp_entry(longint v);
    if (v > ENTRY_LIM) return ENTRY_LIM;
    if (v < -ENTRY_LIM) return -ENTRY_LIM;
    return v;
  endfunction

  // Rotate one point by Rx*Ry*Rz built from the current trig values
  function automatic rot_result_t predict_rotation(coord_t px, coord_t py, coord_t pz);
    longint sx, cx, sy, cy, sz, cz, one;
    longint m[9];
    longint p[3];
    longint acc, r;
    coord_t o[3];
    logic   clip;
    rot_result_t res;
    sx  = trig_now.sx;
    cx  = trig_now.cx;
    sy  = trig_now.sy;
    cy  = trig_now.cy;
    sz  = trig_now.sz;
    cz  = trig_now.cz;
    one = longint'(1) << TRIG_FRAC_BITS;
    m[0] = clamp_entry(round_drop(cy * cz, TRIG_FRAC_BITS));
    m[1] = clamp_entry(round_drop(-(cy * sz), TRIG_FRAC_BITS));
    m[2] = clamp_entry(sy);
    m[3] = clamp_entry(round_drop(sx * sy * cz + cx * sz * one, 2 * TRIG_FRAC_BITS));
    m[4] = clamp_entry(round_drop(cx * cz * one - sx * sy * sz, 2 * TRIG_FRAC_BITS));
    m[5] = clamp_entry(round_drop(-(sx * cy), TRIG_FRAC_BITS));
    m[6] = clamp_entry(round_drop(sx * sz * one - cx * sy * cz, 2 * TRIG_FRAC_BITS));
    m[7] = clamp_entry(round_drop(cx * sy * sz + sx * cz * one, 2 * TRIG_FRAC_BITS));
    m[8] = clamp_entry(round_drop(cx * cy, TRIG_FRAC_BITS));
    p[0] = px;
    p[1] = py;
    p[2] = pz;
    clip = 1'b0;
    for (int i = 0; i < 3; i++) begin
      acc = m[3*i] * p[0] + m[3*i+1] * p[1] + m[3*i+2] * p[2];
      r   = round_drop(acc, TRIG_FRAC_BITS);
      if (r > COORD_MAX) begin
        r    = COORD_MAX;
        clip = 1'b1;
      end else if (r < COORD_MIN) begin
        r    = COORD_MIN;
        clip = 1'b1;
      end
      o[i] = coord_t'(r);
    end
    res.x       = o[0];
    res.y       = o[1];
    res.z       = o[2];
    res.clipped = clip;
    return res;
  endfunction

  function automatic trig_word_t to_q14(real v);
    return trig_word_t'($rtoi(v * real'(longint'(1) << TRIG_FRAC_BITS)
                              + ((v < 0.0) ? -0.5 : 0.5)));
  endfunction

  function automatic trig_word_t edge_trig();
    case ($urandom_range(0, 4))
      0:       return TRIG_MIN;
      1:       return TRIG_MAX;
      2:       return TRIG_ONE;
      3:       return -TRIG_ONE;
      default: return TRIG_ZERO;
    endcase
  endfunction

  // Mostly true rotations, some raw bit patterns, some edge values
  function automatic trig_t random_trig_set();
    trig_t t;
    real   ax, ay, az;
    int    mode;
    mode = $urandom_range(0, 5);
    ax   = real'($urandom_range(0, 35999)) * PI / 18000.0;
    ay   = real'($urandom_range(0, 35999)) * PI / 18000.0;
    az   = real'($urandom_range(0, 35999)) * PI / 18000.0;
    t.sx = to_q14($sin(ax));
    t.cx = to_q14($cos(ax));
    t.sy = to_q14($sin(ay));
    t.cy = to_q14($cos(ay));
    t.sz = to_q14($sin(az));
    t.cz = to_q14($cos(az));
    if (mode == 4) begin
      t = trig_t'({$urandom(), $urandom(), $urandom()});
    end else if (mode == 5) begin
      t.sx = edge_trig();
      t.cx = edge_trig();
      t.sy = edge_trig();
      t.cy = edge_trig();
      t.sz = edge_trig();
      t.cz = edge_trig();
    end
    return t;
  endfunction

  function automatic coord_t random_coord();
    case ($urandom_range(0, 9))
      0, 1: begin
        case ($urandom_range(0, 4))
          0:       return coord_t'(COORD_MIN);
          1:       return coord_t'(COORD_MAX);
          2:       return coord_t'(-1);
          3:       return coord_t'(1);
          default: return coord_t'(0);
        endcase
      end
      2, 3:    return coord_t'(int'($urandom_range(0, 4000)) - 2000);
      default: return coord_t'($urandom());
    endcase
  endfunction

  function automatic void report_mismatch(string what, rot_result_t want, rot_result_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t: %s: expected x=%0d y=%0d z=%0d clipped=%0b, got x=%0d y=%0d z=%0d clipped=%0b",
               $time, what, want.x, want.y, want.z, want.clipped,
               got.x, got.y, got.z, got.clipped);
  endfunction

  // Offer one point and queue its rotation once the transaction completes
  task automatic send_point(input coord_t x, input coord_t y, input coord_t z);
    int gap;
    if (src_gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      pt_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pt_bus.valid <= 1'b1;
    pt_bus.in_x  <= x;
    pt_bus.in_y  <= y;
    pt_bus.in_z  <= z;
    do @(posedge clk); while (!pt_bus.ready);
    rot_expect_q.push_back(predict_rotation(x, y, z));
  endtask

  task automatic send_random_points(input int count);
    for (int k = 0; k < count; k++)
      send_point(random_coord(), random_coord(), random_coord());
  endtask

  // Stop offering, wait for every pending rotation, then let the pipe empty
  task automatic drain_points();
    pt_bus.valid <= 1'b0;
    while (rot_expect_q.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 1) @(posedge clk);
  endtask

  // Setup and access phase, a read back of the same slot, then the bus returns to idle
  task automatic write_trig_reg(input int slot, input trig_word_t value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(slot << 2);
    pwdata  <= {(CFG_DATA_W - TRIG_WIDTH)'($urandom()), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (slot)
      REG_SIN_AX: trig_now.sx = value;
      REG_COS_AX: trig_now.cx = value;
      REG_SIN_AY: trig_now.sy = value;
      REG_COS_AY: trig_now.cy = value;
      REG_SIN_AZ: trig_now.sz = value;
      REG_COS_AZ: trig_now.cz = value;
      default: ;  // unmapped slot: the block drops the write
    endcase
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (slot < NUM_REGS && prdata[TRIG_WIDTH-1:0] !== value) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("%0t: register %0d read back: expected %0h, got %0h",
                 $time, slot, value, prdata[TRIG_WIDTH-1:0]);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_trig_set(input trig_t t);
    drain_points();
    write_trig_reg(REG_SIN_AX, t.sx);
    write_trig_reg(REG_COS_AX, t.cx);
    write_trig_reg(REG_SIN_AY, t.sy);
    write_trig_reg(REG_COS_AY, t.cy);
    write_trig_reg(REG_SIN_AZ, t.sz);
    write_trig_reg(REG_COS_AZ, t.cz);
  endtask

  // Reset angles leave points unchanged, including the range ends
  task automatic test_identity_extremes();
    send_point(coord_t'(0), coord_t'(0), coord_t'(0));
    send_point(coord_t'(COORD_MAX), coord_t'(COORD_MAX), coord_t'(COORD_MAX));
    send_point(coord_t'(COORD_MIN), coord_t'(COORD_MIN), coord_t'(COORD_MIN));
    send_point(coord_t'(1), coord_t'(-1), coord_t'(0));
    send_point(coord_t'(COORD_MIN), coord_t'(COORD_MAX), coord_t'(-1));
    drain_points();
  endtask

  // Quarter turn about each axis alone, then an eighth turn that saturates
  task automatic test_single_axis_turns();
    trig_t t;
    for (int axis = 0; axis < 3; axis++) begin
      t = TRIG_IDENTITY;
      case (axis)
        0: begin
          t.sx = TRIG_ONE;
          t.cx = TRIG_ZERO;
        end
        1: begin
          t.sy = TRIG_ONE;
          t.cy = TRIG_ZERO;
        end
        default: begin
          t.sz = TRIG_ONE;
          t.cz = TRIG_ZERO;
        end
      endcase
      load_trig_set(t);
      send_point(coord_t'(COORD_MAX), coord_t'(COORD_MIN), coord_t'(1000));
      send_point(coord_t'(-1), coord_t'(12345), coord_t'(COORD_MIN));
    end
    t    = TRIG_IDENTITY;
    t.sz = to_q14($sin(PI / 4.0));
    t.cz = to_q14($cos(PI / 4.0));
    load_trig_set(t);
    send_point(coord_t'(COORD_MAX), coord_t'(COORD_MAX), coord_t'(COORD_MIN));
    drain_points();
  endtask

  // Trig words beyond +-1 push matrix entries into their clamp
  task automatic test_trig_out_of_range();
    load_trig_set({TRIG_MIN, TRIG_MIN, TRIG_MIN, TRIG_MIN, TRIG_MIN, TRIG_MIN});
    send_point(coord_t'(COORD_MAX), coord_t'(COORD_MAX), coord_t'(COORD_MAX));
    send_point(coord_t'(COORD_MIN), coord_t'(1), coord_t'(-1));
    load_trig_set({TRIG_MAX, TRIG_MAX, TRIG_MAX, TRIG_MAX, TRIG_MAX, TRIG_MAX});
    send_point(coord_t'(COORD_MAX), coord_t'(COORD_MAX), coord_t'(COORD_MAX));
    send_point(coord_t'(COORD_MIN), coord_t'(1), coord_t'(-1));
    drain_points();
  endtask

  // Writes past the last register must not disturb the matrix
  task automatic test_unmapped_slots();
    drain_points();
    for (int slot = NUM_REGS; slot < ADDR_SLOTS; slot++)
      write_trig_reg(slot, trig_word_t'($urandom()));
    send_random_points(2);
    drain_points();
  endtask

  task automatic test_random_rotations();
    src_gaps_on    = 1'b1;
    sink_stalls_on = 1'b1;
    for (int phase = 0; phase < 12; phase++) begin
      load_trig_set(random_trig_set());
      send_random_points(85);
    end
    drain_points();
  endtask

  // Hold the result side for a long stretch while points keep coming
  task automatic test_output_backpressure();
    src_gaps_on = 1'b0;
    holds_asked++;
    send_random_points(60);
    drain_points();
    src_gaps_on = 1'b1;
  endtask

  // Pause the sender until every pending rotation is back
  task automatic test_sender_pause();
    send_random_points(30);
    drain_points();
    send_random_points(30);
    drain_points();
  endtask

  task automatic test_full_rate();
    src_gaps_on    = 1'b0;
    sink_stalls_on = 1'b0;
    for (int phase = 0; phase < 2; phase++) begin
      load_trig_set(random_trig_set());
      send_random_points(200);
    end
    drain_points();
  endtask

  // Drive ready on the result side: random short stalls, or one long hold on request
  initial begin : result_ready_drive
    int n;
    rot_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        rot_bus.ready <= 1'b0;
      end else if (holds_served != holds_asked) begin
        holds_served++;
        rot_bus.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        rot_bus.ready <= 1'b1;
      end else if (sink_stalls_on && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 4);
        rot_bus.ready <= 1'b0;
        repeat (n) @(posedge clk);
        rot_bus.ready <= 1'b1;
      end else begin
        rot_bus.ready <= 1'b1;
      end
    end
  end

  // Compare each result transaction with the oldest pending rotation
  always @(posedge clk) begin
    rot_result_t got;
    rot_result_t want;
    if (!rst && rot_bus.valid && rot_bus.ready) begin
      got = '{rot_bus.out_x, rot_bus.out_y, rot_bus.out_z, rot_bus.clipped};
      if (rot_expect_q.size() == 0) begin
        report_mismatch("result with nothing pending", '0, got);
      end else begin
        want = rot_expect_q.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
            got.clipped !== want.clipped)
          report_mismatch("rotation mismatch", want, got);
      end
    end
  end

  initial begin
    #(longint'(TIMEOUT_CYCLES) * CLK_PERIOD);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst            = 1'b1;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    pt_bus.valid   = 1'b0;
    pt_bus.in_x    = '0;
    pt_bus.in_y    = '0;
    pt_bus.in_z    = '0;
    trig_now       = TRIG_IDENTITY;
    mismatch_count = 0;
    holds_asked    = 0;
    holds_served   = 0;
    src_gaps_on    = 1'b1;
    sink_stalls_on = 1'b1;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_identity_extremes();
    test_single_axis_turns();
    test_trig_out_of_range();
    test_unmapped_slots();
    test_random_rotations();
    test_output_backpressure();
    test_sender_pause();
    test_full_rate();

    if (mismatch_count == 0 && rot_expect_q.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
